### sv/cpe_pkg.sv
// types, constants and helper functions for the complex polynomial evaluator
package cpe_pkg;

  localparam int MAX_TERMS_DEF = 64;
  localparam int DEG_W         = 6;
  localparam int COEF_W        = 32;
  localparam int PT_W          = 32;
  localparam int VAL_W         = 64;
  localparam int OPA_W         = 33;
  localparam int PROD_W        = OPA_W + COEF_W;
  localparam int ACC_W         = 98;
  localparam int STEP_W        = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [STEP_W-1:0] STEP_COEF_LAST = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TOP_END   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_PWR_LAST  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_TERM_END  = 4'd13;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_DONE} state_t;
  typedef enum logic [1:0] {OPA_PR_LO, OPA_PR_HI, OPA_PI_LO, OPA_PI_HI} opa_sel_t;
  typedef enum logic [1:0] {OPB_COEF, OPB_AR, OPB_AI} opb_sel_t;
  typedef enum logic [1:0] {DST_SUM_RE, DST_SUM_IM, DST_PWR_RE, DST_PWR_IM} dst_t;

  typedef struct packed {
    opa_sel_t a_sel;
    opb_sel_t b_sel;
    logic     sh32;
    logic     neg;
    logic     first;
    logic     last;
    dst_t     dst;
  } slot_t;

  typedef struct packed {
    logic             ovf;
    logic [VAL_W-1:0] val;
  } res_t;

  // product schedule of one term
  function automatic slot_t slot_decode(input logic [STEP_W-1:0] step);
    slot_t s;
    s = '0;
    unique case (step)
      4'd0:  s = '{OPA_PR_LO, OPB_COEF, 1'b0, 1'b0, 1'b1, 1'b0, DST_SUM_RE};
      4'd1:  s = '{OPA_PR_HI, OPB_COEF, 1'b1, 1'b0, 1'b0, 1'b1, DST_SUM_RE};
      4'd2:  s = '{OPA_PI_LO, OPB_COEF, 1'b0, 1'b0, 1'b1, 1'b0, DST_SUM_IM};
      4'd3:  s = '{OPA_PI_HI, OPB_COEF, 1'b1, 1'b0, 1'b0, 1'b1, DST_SUM_IM};
      4'd4:  s = '{OPA_PR_LO, OPB_AR,   1'b0, 1'b0, 1'b1, 1'b0, DST_PWR_RE};
      4'd5:  s = '{OPA_PR_HI, OPB_AR,   1'b1, 1'b0, 1'b0, 1'b0, DST_PWR_RE};
      4'd6:  s = '{OPA_PI_LO, OPB_AI,   1'b0, 1'b1, 1'b0, 1'b0, DST_PWR_RE};
      4'd7:  s = '{OPA_PI_HI, OPB_AI,   1'b1, 1'b1, 1'b0, 1'b1, DST_PWR_RE};
      4'd8:  s = '{OPA_PR_LO, OPB_AI,   1'b0, 1'b0, 1'b1, 1'b0, DST_PWR_IM};
      4'd9:  s = '{OPA_PR_HI, OPB_AI,   1'b1, 1'b0, 1'b0, 1'b0, DST_PWR_IM};
      4'd10: s = '{OPA_PI_LO, OPB_AR,   1'b0, 1'b0, 1'b0, 1'b0, DST_PWR_IM};
      4'd11: s = '{OPA_PI_HI, OPB_AR,   1'b1, 1'b0, 1'b0, 1'b1, DST_PWR_IM};
      default: s = '0;
    endcase
    return s;
  endfunction

  // arithmetic shift right by 16, saturated to 64 bits
  function automatic res_t shift_sat(input logic [ACC_W-1:0] x);
    res_t r;
    logic [ACC_W-VAL_W-16:0] top;
    top   = x[ACC_W-1:VAL_W+15];
    r.ovf = !((&top) || !(|top));
    r.val = r.ovf ? (x[ACC_W-1] ? VAL_MIN : VAL_MAX) : x[VAL_W+15:16];
    return r;
  endfunction

  function automatic res_t sat_add(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    res_t r;
    logic [VAL_W-1:0] s;
    s     = a + b;
    r.ovf = (a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1]);
    r.val = r.ovf ? (a[VAL_W-1] ? VAL_MIN : VAL_MAX) : s;
    return r;
  endfunction

endpackage

### sv/cpe_ram.sv
// generic single-port-write ram with registered read
module cpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/complex_polynomial_evaluator_top.sv
// complex polynomial evaluator: real coefficients, complex point, shared multiplier
//
// A start with cmd 0 writes one Q16.16 coefficient and gives no result. A start
// with cmd 1 evaluates the polynomial at the Q16.16 point and raises done for
// exactly one cycle, with Q32.32 sums and the saturated flag on value_real,
// value_imag and saturated; the receiver cannot stall, so it must take the result
// in that cycle. With t = min(degree, MAX_TERMS-1), an evaluation covers terms 0
// to t, and busy stays high from the start transfer through the done pulse. The
// single 33x32 multiplier forms twelve partial products per term (four for the
// sums, eight for the power update), but only the four for the sums for term t;
// each product is registered and then accumulated. After reset the block sweeps
// the coefficient store to zero with busy high; cfg_ready is high only while the
// block is idle, so the degree register changes between items.
module complex_polynomial_evaluator_top
  import cpe_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cmd,
  input  logic [DEG_W-1:0]        coef_power,
  input  logic signed [COEF_W-1:0] coef_value,
  input  logic signed [PT_W-1:0]  point_real,
  input  logic signed [PT_W-1:0]  point_imag,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [DEG_W-1:0]        cfg_data,
  output logic                    done,
  output logic signed [VAL_W-1:0] value_real,
  output logic signed [VAL_W-1:0] value_imag,
  output logic                    saturated
);

  localparam int AW = $clog2(MAX_TERMS);
  localparam int CW = AW + 7;

  state_t state, state_next;

  logic [DEG_W-1:0]  degree;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     k;
  logic [STEP_W-1:0] step;
  logic [PT_W-1:0]   ar, ai;
  logic [VAL_W-1:0]  pr, pi, pr_tmp;
  logic [VAL_W-1:0]  accr, acci;
  logic              sat;

  logic                     p_valid;
  slot_t                    p_slot;
  logic signed [PROD_W-1:0] prod;
  logic                     a_valid;
  slot_t                    a_slot;
  logic [ACC_W-1:0]         acc;

  logic              accept;
  logic [CW-1:0]     deg_ext, pow_ext;
  logic [AW-1:0]     top;
  logic              last_term;
  logic              issue;
  slot_t             slot;
  logic signed [OPA_W-1:0]  a_op;
  logic signed [COEF_W-1:0] b_op;
  logic signed [ACC_W-1:0]  t_ext, t_sh, t_add;
  logic [ACC_W-1:0]  acc_next;
  res_t              fin, sum;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [COEF_W-1:0] ram_wr_data;
  logic [COEF_W-1:0] ram_rd_data;

  cpe_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TERMS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (k),
    .rd_data (ram_rd_data)
  );

  assign accept    = start && !busy;
  assign deg_ext   = CW'(degree);
  assign pow_ext   = CW'(coef_power);
  assign top       = (deg_ext < CW'(MAX_TERMS)) ? deg_ext[AW-1:0] : AW'(MAX_TERMS - 1);
  assign last_term = (k == top);
  assign issue     = (state == ST_RUN) && (step <= STEP_PWR_LAST)
                     && ((step <= STEP_COEF_LAST) || !last_term);
  assign slot      = slot_decode(step);

  always_comb begin
    unique case (slot.a_sel)
      OPA_PR_LO: a_op = {1'b0, pr[31:0]};
      OPA_PR_HI: a_op = {pr[VAL_W-1], pr[VAL_W-1:32]};
      OPA_PI_LO: a_op = {1'b0, pi[31:0]};
      OPA_PI_HI: a_op = {pi[VAL_W-1], pi[VAL_W-1:32]};
      default:   a_op = '0;
    endcase
    unique case (slot.b_sel)
      OPB_COEF: b_op = ram_rd_data;
      OPB_AR:   b_op = ar;
      OPB_AI:   b_op = ai;
      default:  b_op = '0;
    endcase
  end

  always_comb begin
    t_ext    = ACC_W'(prod);
    t_sh     = p_slot.sh32 ? (t_ext <<< 32) : t_ext;
    t_add    = p_slot.neg ? -t_sh : t_sh;
    acc_next = (p_slot.first ? '0 : acc) + t_add;
    fin      = shift_sat(acc);
    sum      = sat_add((a_slot.dst == DST_SUM_RE) ? accr : acci, fin.val);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(MAX_TERMS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept && cmd == CMD_EVAL) state_next = ST_RUN;
      ST_RUN:   if (last_term && step == STEP_TOP_END) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    cfg_ready   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pow_ext[AW-1:0];
    ram_wr_data = coef_value;
    unique case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
        ram_wr_en = start && (cmd == CMD_WRITE) && (pow_ext < CW'(MAX_TERMS));
      end
      ST_RUN: begin
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign value_real = accr;
  assign value_imag = acci;
  assign saturated  = sat;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      degree   <= '0;
      clr_addr <= '0;
      k        <= '0;
      step     <= '0;
      p_valid  <= 1'b0;
      a_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= issue;
      a_valid <= p_valid;
      if (cfg_valid && cfg_ready) begin
        degree <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_IDLE && accept) begin
        step <= '0;
        k    <= '0;
      end else if (state == ST_RUN) begin
        if (step == STEP_TERM_END) begin
          step <= '0;
        end else begin
          step <= step + 1'b1;
        end
        if (step == STEP_PWR_LAST && !last_term) begin
          k <= k + 1'b1;
        end
      end else if (state == ST_DONE) begin
        k <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (issue) begin
      prod   <= PROD_W'(a_op) * PROD_W'(b_op);
      p_slot <= slot;
    end
    if (p_valid) begin
      acc    <= acc_next;
      a_slot <= p_slot;
    end
    if (state == ST_IDLE && accept && cmd == CMD_EVAL) begin
      ar   <= point_real;
      ai   <= point_imag;
      pr   <= VAL_W'(64'h0000_0001_0000_0000);
      pi   <= '0;
      accr <= '0;
      acci <= '0;
      sat  <= 1'b0;
    end else if (a_valid && a_slot.last) begin
      unique case (a_slot.dst)
        DST_SUM_RE: begin
          accr <= sum.val;
          sat  <= sat | fin.ovf | sum.ovf;
        end
        DST_SUM_IM: begin
          acci <= sum.val;
          sat  <= sat | fin.ovf | sum.ovf;
        end
        DST_PWR_RE: begin
          pr_tmp <= fin.val;
          sat    <= sat | fin.ovf;
        end
        DST_PWR_IM: begin
          pr  <= pr_tmp;
          pi  <= fin.val;
          sat <= sat | fin.ovf;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### dv/poly_eval_checker.sv
// checker for the complex polynomial evaluator: tracks coefficients and degree, predicts and compares
module poly_eval_checker
  import cpe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     cmd,
  input  logic [DEG_W-1:0]         coef_power,
  input  logic signed [COEF_W-1:0] coef_value,
  input  logic signed [PT_W-1:0]   point_real,
  input  logic signed [PT_W-1:0]   point_imag,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [DEG_W-1:0]         cfg_data,
  input  logic                     done,
  input  logic signed [VAL_W-1:0]  value_real,
  input  logic signed [VAL_W-1:0]  value_imag,
  input  logic                     saturated,
  output int                       fail_count,
  output int                       pending
);

  localparam int STORE_DEPTH = MAX_TERMS_DEF;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;

  typedef struct packed {
    logic signed [63:0] re;
    logic signed [63:0] im;
    logic               sat;
  } poly_value_t;

  logic signed [COEF_W-1:0] coef_store [STORE_DEPTH];
  logic [DEG_W-1:0]         degree_q;
  poly_value_t              value_queue [$];
  poly_value_t              want;

  function automatic logic signed [127:0] mul_wide(input logic signed [63:0] a,
                                                   input logic signed [31:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // drop 16 fraction bits, clamp to 64 bits
  function automatic logic signed [63:0] scale_sat(input logic signed [127:0] x,
                                                   inout logic flag);
    logic signed [127:0] s;
    s = x >>> 16;
    if (s[127:63] != {65{s[63]}}) begin
      flag = 1'b1;
      return s[127] ? Q_MIN : Q_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_accum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   inout logic flag);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      flag = 1'b1;
      return s[64] ? Q_MIN : Q_MAX;
    end
    return s[63:0];
  endfunction

  function automatic poly_value_t evaluate_at(input logic signed [31:0] zr,
                                              input logic signed [31:0] zi);
    poly_value_t        v;
    logic signed [63:0] pr;
    logic signed [63:0] pi;
    logic signed [63:0] term;
    logic signed [63:0] nr;
    logic               flag;
    int                 top;
    top  = (degree_q < STORE_DEPTH) ? int'(degree_q) : STORE_DEPTH - 1;
    pr   = Q_ONE;
    pi   = '0;
    v    = '0;
    flag = 1'b0;
    for (int k = 0; k <= top; k++) begin
      term = scale_sat(mul_wide(pr, coef_store[k]), flag);
      v.re = sat_accum(v.re, term, flag);
      term = scale_sat(mul_wide(pi, coef_store[k]), flag);
      v.im = sat_accum(v.im, term, flag);
      // no power step after the highest term
      if (k < top) begin
        nr = scale_sat(mul_wide(pr, zr) - mul_wide(pi, zi), flag);
        pi = scale_sat(mul_wide(pr, zi) + mul_wide(pi, zr), flag);
        pr = nr;
      end
    end
    v.sat = flag;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (coef_store[i]) coef_store[i] = '0;
      degree_q = '0;
      value_queue.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (value_queue.size() == 0) begin
          $error("result transfer with no evaluation outstanding");
          fail_count++;
        end else begin
          want = value_queue.pop_front();
          if (value_real !== want.re) begin
            $error("value_real: expected %h, got %h", want.re, value_real);
            fail_count++;
          end
          if (value_imag !== want.im) begin
            $error("value_imag: expected %h, got %h", want.im, value_imag);
            fail_count++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, saturated);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) degree_q = cfg_data;
      if (start && !busy) begin
        if (cmd == CMD_WRITE) begin
          if (coef_power < STORE_DEPTH) coef_store[coef_power] = coef_value;
        end else begin
          value_queue.insert(value_queue.size(), evaluate_at(point_real, point_imag));
        end
      end
    end
    pending = value_queue.size();
  end

endmodule

### dv/testbench.sv
// testbench top for the complex polynomial evaluator: stimulus, timeout and verdict
module testbench
  import cpe_pkg::*;
();

  localparam int          RANDOM_ITEMS  = 1130;
  localparam int          PHASES        = 12;
  localparam int          SETTLE_CYCLES = 24;
  localparam longint      CYCLE_LIMIT   = 5_000_000;
  localparam logic [31:0] Q16_ONE       = 32'h0001_0000;
  localparam logic [31:0] Q16_NEG_ONE   = 32'hFFFF_0000;
  localparam logic [31:0] Q16_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN       = 32'h8000_0000;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     cmd;
  logic [DEG_W-1:0]         coef_power;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [PT_W-1:0]   point_real;
  logic signed [PT_W-1:0]   point_imag;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [DEG_W-1:0]         cfg_data;
  logic                     done;
  logic signed [VAL_W-1:0]  value_real;
  logic signed [VAL_W-1:0]  value_imag;
  logic                     saturated;
  int                       fail_count;
  int                       pending;
  longint                   cycle_count = 0;
  logic [DEG_W-1:0]         degree_plan [8] = '{6'd63, 6'd1, 6'd0, 6'd2, 6'd5, 6'd62, 6'd3, 6'd7};

  complex_polynomial_evaluator_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .coef_power (coef_power),
    .coef_value (coef_value),
    .point_real (point_real),
    .point_imag (point_imag),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .value_real (value_real),
    .value_imag (value_imag),
    .saturated  (saturated)
  );

  poly_eval_checker i_poly_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .coef_power (coef_power),
    .coef_value (coef_value),
    .point_real (point_real),
    .point_imag (point_imag),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .value_real (value_real),
    .value_imag (value_imag),
    .saturated  (saturated),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL complex_polynomial_evaluator_top");
      $finish;
    end
  end

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom;
    if (r < 7) return 32'($urandom_range(0, 524288)) - 32'd262144;
    return 32'($urandom_range(0, 65536)) - 32'd32768;
  endfunction

  // mostly points near the unit circle so long polynomials stay in range
  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($urandom_range(0, 144178)) - 32'd72089;
    if (r < 8) return 32'($urandom_range(0, 32768)) - 32'd16384;
    return $urandom;
  endfunction

  // called at a falling edge; start stays high when gap is zero
  task automatic send_item(input logic c, input logic [DEG_W-1:0] pw, input logic [31:0] cv,
                           input logic [31:0] pr, input logic [31:0] pi, input int gap);
    cmd        = c;
    coef_power = pw;
    coef_value = cv;
    point_real = pr;
    point_imag = pi;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_coef(input logic [DEG_W-1:0] pw, input logic [31:0] cv, input int gap);
    send_item(CMD_WRITE, pw, cv, $urandom, $urandom, gap);
  endtask

  task automatic eval_point(input logic [31:0] pr, input logic [31:0] pi, input int gap);
    send_item(CMD_EVAL, DEG_W'($urandom), $urandom, pr, pi, gap);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_degree(input logic [DEG_W-1:0] d);
    drain();
    cfg_data  = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [DEG_W-1:0] deg;
    bit               burst;
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_WRITE;
    coef_power = '0;
    coef_value = '0;
    point_real = '0;
    point_imag = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // constant term only, empty store first
    set_degree(6'd0);
    eval_point(32'h0, 32'h0, pick_gap(0));
    write_coef(6'd0, Q16_MAX, pick_gap(0));
    eval_point(Q16_MIN, Q16_MAX, pick_gap(0));
    write_coef(6'd63, Q16_MIN, pick_gap(0));
    write_coef(6'd1, Q16_ONE, pick_gap(0));
    write_coef(6'd2, Q16_NEG_ONE, pick_gap(0));

    // largest point: the square fits, the skipped cube would not
    set_degree(6'd2);
    eval_point(Q16_MAX, 32'h0, pick_gap(0));
    eval_point(32'h0, Q16_ONE, pick_gap(0));
    eval_point(Q16_MIN, Q16_MIN, pick_gap(0));

    set_degree(6'd63);
    eval_point(32'h0, 32'h0, pick_gap(0));
    eval_point(Q16_ONE, 32'h0, pick_gap(0));
    eval_point(Q16_NEG_ONE, 32'h0, pick_gap(0));
    eval_point(32'h0, Q16_NEG_ONE, pick_gap(0));
    eval_point(Q16_MAX, Q16_MAX, pick_gap(0));
    eval_point(Q16_MIN, 32'h0, pick_gap(0));
    write_coef(6'd62, Q16_MAX, pick_gap(0));
    write_coef(6'd31, Q16_MIN, pick_gap(0));
    eval_point(Q16_ONE, 32'h0, pick_gap(0));
    eval_point(32'h0000_FFFF, 32'h0000_0001, pick_gap(0));

    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) deg = degree_plan[p];
      else if (p == 8) deg = DEG_W'($urandom_range(0, 63));
      else deg = DEG_W'($urandom_range(0, 8));
      set_degree(deg);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if ($urandom_range(0, 1)) begin
          write_coef(DEG_W'($urandom_range(0, 63)), rand_coef(), pick_gap(burst));
        end else begin
          eval_point(rand_coord(), rand_coord(), pick_gap(burst));
        end
      end
    end

    drain();
    if (fail_count == 0) $display("PASS complex_polynomial_evaluator_top");
    else $display("FAIL complex_polynomial_evaluator_top");
    $finish;
  end

endmodule
